/* hdl/page_frame_table_lru_macros.svh */
// Assertion macros for the page frame table.
// Each macro expects clk and rst in scope at the point of use.
`ifndef PAGE_FRAME_TABLE_LRU_MACROS_SVH
`define PAGE_FRAME_TABLE_LRU_MACROS_SVH
`ifndef SYNTHESIS
// The consequent must hold in the same cycle as the antecedent.
`define PFT_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("page frame table check failed");
// The consequent must hold in the cycle after the antecedent.
`define PFT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("page frame table check failed");
`else
`define PFT_ASSERT_SAME(label, ante, cons)
`define PFT_ASSERT_NEXT(label, ante, cons)
`endif
`endif

/* hdl/pft_pkg.sv */
package pft_pkg;

  // Default table size.
  localparam int FRAMES_DEFAULT = 256;

  // Command codes.
  localparam logic [2:0] CMD_LOOKUP = 3'd0;
  localparam logic [2:0] CMD_LOAD   = 3'd1;
  localparam logic [2:0] CMD_SETD   = 3'd2;
  localparam logic [2:0] CMD_FLUSHF = 3'd3;
  localparam logic [2:0] CMD_FLUSHP = 3'd4;
  localparam logic [2:0] CMD_QUERY  = 3'd5;

  // Operations of the shared entry unit.
  localparam logic [1:0] UOP_NONE  = 2'd0;
  localparam logic [1:0] UOP_TOUCH = 2'd1;
  localparam logic [1:0] UOP_LOAD  = 2'd2;
  localparam logic [1:0] UOP_DIRTY = 2'd3;

  // Side effect applied to the touched frame.
  localparam logic [1:0] FX_NONE  = 2'd0;
  localparam logic [1:0] FX_WAIT  = 2'd1;
  localparam logic [1:0] FX_EMPTY = 2'd2;

  typedef struct packed {
    logic [2:0] cmd;
    logic [7:0] proc;
    logic [7:0] page;
    logic [7:0] frame_index;
    logic       write_access;
  } in_t;

  typedef struct packed {
    logic       hit;
    logic [7:0] frame;
    logic       dirty;
  } out_t;

  // Per-frame marks, stored next to the recency rank.
  typedef struct packed {
    logic       valid;
    logic [7:0] proc;
    logic [7:0] page;
    logic       dirty;
    logic       waiting;
  } meta_t;

  // Compare results of the entry unit.
  typedef struct packed {
    logic match;
    logic pmatch;
    logic free;
    logic lru;
  } flags_t;

endpackage

/* hdl/pft_mem.sv */
module pft_mem #(
  parameter int DEPTH = pft_pkg::FRAMES_DEFAULT,
  parameter int AW    = 8,
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    wa,
  input  logic [WIDTH-1:0] wd,
  input  logic [AW-1:0]    ra,
  output logic [WIDTH-1:0] rd
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd <= mem[ra];
  end

endmodule

/* hdl/pft_unit.sv */
module pft_unit #(
  parameter int FRAMES = pft_pkg::FRAMES_DEFAULT,
  parameter int AW     = 8
) (
  input  logic [1:0]          uop,
  input  logic [1:0]          fx,
  input  logic [AW-1:0]       idx,
  input  logic [AW-1:0]       tgt,
  input  logic [AW-1:0]       tgt_rank,
  input  logic [7:0]          key_proc,
  input  logic [7:0]          key_page,
  input  logic                wr,
  input  pft_pkg::meta_t      meta_in,
  input  logic [AW-1:0]       rank_in,
  output pft_pkg::meta_t      meta_out,
  output logic [AW-1:0]       rank_out,
  output pft_pkg::flags_t     flags
);

  localparam logic [AW-1:0] LAST = AW'(FRAMES - 1);

  // Compares used by the search passes.
  always_comb begin
    flags.match  = meta_in.valid && (meta_in.proc == key_proc) && (meta_in.page == key_page);
    flags.pmatch = meta_in.valid && (meta_in.proc == key_proc);
    flags.free   = !meta_in.valid && !meta_in.waiting;
    flags.lru    = (rank_in == LAST);
  end

  // Update of one entry.
  always_comb begin
    meta_out = meta_in;
    rank_out = rank_in;
    case (uop)
      pft_pkg::UOP_TOUCH: begin
        if (idx == tgt) begin
          rank_out = '0;
          case (fx)
            pft_pkg::FX_WAIT: begin
              meta_out.waiting = 1'b1;
            end
            pft_pkg::FX_EMPTY: begin
              meta_out.valid   = 1'b0;
              meta_out.dirty   = 1'b0;
              meta_out.waiting = 1'b0;
            end
            default: begin
            end
          endcase
        end else if (rank_in < tgt_rank) begin
          rank_out = rank_in + 1'b1;
        end
      end
      pft_pkg::UOP_LOAD: begin
        meta_out.valid   = 1'b1;
        meta_out.proc    = key_proc;
        meta_out.page    = key_page;
        meta_out.dirty   = meta_in.dirty | wr;
        meta_out.waiting = 1'b0;
      end
      pft_pkg::UOP_DIRTY: begin
        meta_out.dirty = meta_in.dirty | wr;
      end
      default: begin
      end
    endcase
  end

endmodule

/* hdl/page_frame_table_lru.sv */
// Frame table with least-recently-used replacement. One command word is taken at a time
// and answered with one result word; the table sits in a memory with one write port and one
// registered read port that is walked one frame per cycle by a shared compare-and-update
// unit. A lookup makes a search pass, then a recency pass; flush-frame reads the frame, then
// makes a recency pass; load and set-dirty read and write back one frame, query only reads it.
// Flush-process makes one search pass plus one recency pass for every frame it empties.
// After reset the block initializes every frame of the memory before it accepts its first word.
`include "page_frame_table_lru_macros.svh"

module page_frame_table_lru #(
  parameter int FRAMES = pft_pkg::FRAMES_DEFAULT
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  pft_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output pft_pkg::out_t out_data
);

  localparam int AW = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int CW = AW + 1;
  localparam int MW = $bits(pft_pkg::meta_t);
  localparam int EW = MW + AW;
  localparam logic [CW-1:0] CNT_END = CW'(FRAMES);
  localparam logic [AW-1:0] LAST = AW'(FRAMES - 1);

  localparam logic [2:0] S_CLR   = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_READ  = 3'd2;
  localparam logic [2:0] S_RMW   = 3'd3;
  localparam logic [2:0] S_SCAN  = 3'd4;
  localparam logic [2:0] S_TOUCH = 3'd5;
  localparam logic [2:0] S_FSCAN = 3'd6;
  localparam logic [2:0] S_OUT   = 3'd7;

  logic [2:0]      state;
  logic [CW-1:0]   cnt;
  logic            pvld;
  logic [AW-1:0]   pidx;
  pft_pkg::in_t    cur;
  logic [AW-1:0]   tgt;
  logic [AW-1:0]   tgt_rank;
  logic [1:0]      fx;
  pft_pkg::out_t   res;

  // Candidates gathered by the lookup search.
  logic            hit_f, free_f;
  logic [AW-1:0]   hit_i, free_i, lru_i;
  logic [AW-1:0]   hit_r, free_r;
  logic            hit_d, free_d, lru_d;

  logic            hit_any, free_any;
  logic [AW-1:0]   hit_i_next, free_i_next, lru_i_next;
  logic [AW-1:0]   hit_r_next, free_r_next;
  logic            hit_d_next, free_d_next, lru_d_next;

  logic            mem_we;
  logic [AW-1:0]   mem_wa, mem_ra;
  logic [EW-1:0]   mem_wd, mem_rd;
  pft_pkg::meta_t  meta_in, meta_out;
  logic [AW-1:0]   rank_in, rank_out;
  pft_pkg::flags_t flags;
  logic [1:0]      uop;
  logic            issue, last_p, in_range;

  assign meta_in  = pft_pkg::meta_t'(mem_rd[EW-1:AW]);
  assign rank_in  = mem_rd[AW-1:0];
  assign issue    = (cnt < CNT_END);
  assign last_p   = pvld && (pidx == LAST);
  assign in_range = (32'(in_data.frame_index) < 32'(FRAMES));
  assign in_ready = (state == S_IDLE);

  pft_mem #(.DEPTH(FRAMES), .AW(AW), .WIDTH(EW)) u_mem (
    .clk (clk),
    .we  (mem_we),
    .wa  (mem_wa),
    .wd  (mem_wd),
    .ra  (mem_ra),
    .rd  (mem_rd)
  );

  pft_unit #(.FRAMES(FRAMES), .AW(AW)) u_unit (
    .uop      (uop),
    .fx       (fx),
    .idx      (pidx),
    .tgt      (tgt),
    .tgt_rank (tgt_rank),
    .key_proc (cur.proc),
    .key_page (cur.page),
    .wr       (cur.write_access),
    .meta_in  (meta_in),
    .rank_in  (rank_in),
    .meta_out (meta_out),
    .rank_out (rank_out),
    .flags    (flags)
  );

  // Unit operation for the current state.
  always_comb begin
    uop = pft_pkg::UOP_NONE;
    if (state == S_TOUCH) begin
      uop = pft_pkg::UOP_TOUCH;
    end else if (state == S_RMW) begin
      if (cur.cmd == pft_pkg::CMD_LOAD) begin
        uop = pft_pkg::UOP_LOAD;
      end else if (cur.cmd == pft_pkg::CMD_SETD) begin
        uop = pft_pkg::UOP_DIRTY;
      end
    end
  end

  // Memory port steering.
  always_comb begin
    mem_ra = (state == S_READ) ? tgt : cnt[AW-1:0];
    mem_we = 1'b0;
    mem_wa = pidx;
    mem_wd = {meta_out, rank_out};
    case (state)
      S_CLR: begin
        mem_we = 1'b1;
        mem_wa = cnt[AW-1:0];
        mem_wd = {MW'(0), LAST - cnt[AW-1:0]};
      end
      S_TOUCH: begin
        mem_we = pvld;
      end
      S_RMW: begin
        mem_we = (cur.cmd == pft_pkg::CMD_LOAD) || (cur.cmd == pft_pkg::CMD_SETD);
        mem_wa = tgt;
      end
      default: begin
      end
    endcase
  end

  // Lowest matching frame, lowest free frame and the oldest frame seen so far.
  always_comb begin
    hit_any     = hit_f || (pvld && flags.match);
    hit_i_next  = hit_f ? hit_i : pidx;
    hit_r_next  = hit_f ? hit_r : rank_in;
    hit_d_next  = hit_f ? hit_d : meta_in.dirty;
    free_any    = free_f || (pvld && flags.free);
    free_i_next = free_f ? free_i : pidx;
    free_r_next = free_f ? free_r : rank_in;
    free_d_next = free_f ? free_d : meta_in.dirty;
    lru_i_next  = (pvld && flags.lru) ? pidx : lru_i;
    lru_d_next  = (pvld && flags.lru) ? meta_in.dirty : lru_d;
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLR;
      cnt       <= '0;
      pvld      <= 1'b0;
      out_valid <= 1'b0;
      hit_f     <= 1'b0;
      free_f    <= 1'b0;
    end else begin
      case (state)
        S_CLR: begin
          if (cnt == CNT_END - 1'b1) begin
            cnt   <= '0;
            state <= S_IDLE;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            cur    <= in_data;
            cnt    <= '0;
            pvld   <= 1'b0;
            hit_f  <= 1'b0;
            free_f <= 1'b0;
            lru_i  <= '0;
            lru_d  <= 1'b0;
            if (in_data.cmd == pft_pkg::CMD_LOOKUP) begin
              state <= S_SCAN;
            end else if (in_data.cmd == pft_pkg::CMD_FLUSHP) begin
              state <= S_FSCAN;
            end else if (in_range) begin
              tgt   <= AW'(in_data.frame_index);
              state <= S_READ;
            end else begin
              res       <= '{hit: 1'b0, frame: in_data.frame_index, dirty: 1'b0};
              out_valid <= 1'b1;
              state     <= S_OUT;
            end
          end
        end
        S_READ: begin
          state <= S_RMW;
        end
        S_RMW: begin
          if (cur.cmd == pft_pkg::CMD_FLUSHF) begin
            tgt_rank <= rank_in;
            fx       <= pft_pkg::FX_EMPTY;
            cnt      <= '0;
            pvld     <= 1'b0;
            res      <= '{hit: 1'b0, frame: cur.frame_index, dirty: 1'b0};
            state    <= S_TOUCH;
          end else begin
            res       <= '{hit: 1'b0, frame: cur.frame_index, dirty: meta_out.dirty};
            out_valid <= 1'b1;
            state     <= S_OUT;
          end
        end
        S_SCAN: begin
          pidx   <= cnt[AW-1:0];
          hit_f  <= hit_any;
          hit_i  <= hit_i_next;
          hit_r  <= hit_r_next;
          hit_d  <= hit_d_next;
          free_f <= free_any;
          free_i <= free_i_next;
          free_r <= free_r_next;
          free_d <= free_d_next;
          lru_i  <= lru_i_next;
          lru_d  <= lru_d_next;
          if (last_p) begin
            cnt  <= '0;
            pvld <= 1'b0;
            if (hit_any) begin
              tgt      <= hit_i_next;
              tgt_rank <= hit_r_next;
              fx       <= pft_pkg::FX_NONE;
              res      <= '{hit: 1'b1, frame: 8'(hit_i_next), dirty: hit_d_next};
            end else if (free_any) begin
              tgt      <= free_i_next;
              tgt_rank <= free_r_next;
              fx       <= pft_pkg::FX_WAIT;
              res      <= '{hit: 1'b0, frame: 8'(free_i_next), dirty: free_d_next};
            end else begin
              tgt      <= lru_i_next;
              tgt_rank <= LAST;
              fx       <= pft_pkg::FX_WAIT;
              res      <= '{hit: 1'b0, frame: 8'(lru_i_next), dirty: lru_d_next};
            end
            state <= S_TOUCH;
          end else begin
            if (issue) begin
              cnt <= cnt + 1'b1;
            end
            pvld <= issue;
          end
        end
        S_TOUCH: begin
          pidx <= cnt[AW-1:0];
          if (last_p) begin
            pvld <= 1'b0;
            if ((cur.cmd == pft_pkg::CMD_FLUSHP) && (tgt != LAST)) begin
              cnt   <= CW'(tgt) + 1'b1;
              state <= S_FSCAN;
            end else begin
              if (cur.cmd == pft_pkg::CMD_FLUSHP) begin
                res <= '0;
              end
              out_valid <= 1'b1;
              state     <= S_OUT;
            end
          end else begin
            if (issue) begin
              cnt <= cnt + 1'b1;
            end
            pvld <= issue;
          end
        end
        S_FSCAN: begin
          pidx <= cnt[AW-1:0];
          if (pvld && flags.pmatch) begin
            tgt      <= pidx;
            tgt_rank <= rank_in;
            fx       <= pft_pkg::FX_EMPTY;
            cnt      <= '0;
            pvld     <= 1'b0;
            state    <= S_TOUCH;
          end else if (last_p) begin
            pvld      <= 1'b0;
            res       <= '0;
            out_valid <= 1'b1;
            state     <= S_OUT;
          end else begin
            if (issue) begin
              cnt <= cnt + 1'b1;
            end
            pvld <= issue;
          end
        end
        S_OUT: begin
          if (out_ready) begin
            out_valid <= 1'b0;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign out_data = res;

  // Checks on the sequencer.
  `PFT_ASSERT_SAME(a_ready_no_result, in_ready, !out_valid)
  `PFT_ASSERT_NEXT(a_accept_leaves_idle, in_valid && in_ready, state != S_IDLE)
  `PFT_ASSERT_SAME(a_hit_only_lookup, out_valid && out_data.hit, cur.cmd == pft_pkg::CMD_LOOKUP)
  `PFT_ASSERT_SAME(a_pipe_in_pass, pvld, (state == S_SCAN) || (state == S_TOUCH) || (state == S_FSCAN))

endmodule
